// ===== rtl/nlfsr_pkg.sv =====
// Shared types and constants for the feedback shift register period checker.
package nlfsr_pkg;

   localparam int TABLE_W   = 32;
   localparam int BITS_W    = 32;
   localparam int STEPS_W   = 6;
   localparam int CNT_W     = 7;
   localparam int MAX_ORDER = 6;
   localparam int RSP_W     = 40;

   typedef struct packed {
      logic load;
      logic step;
      logic publish;
   } nlfsr_cmd_type;

   typedef struct packed {
      logic last;
   } nlfsr_status_type;

endpackage

// ===== rtl/nlfsr_full_period_checker.sv =====
// Top level of the feedback shift register full period checker.
//
//  channel | direction | tdata fields (low bit up)
//  req_    | in        | feedback_table[31:0]
//  rsp_    | out       | full_period, returned_to_zero, steps_taken[5:0], emitted_bits[31:0]
//
// One word is loaded, then shifted one step at a time (2^ORDER+3 steps at most,
// set by the single-step shift register loop), and then its result is handed off.
// Reset clears the controller and the output valid; no clearing pass.
// A stalled result holds in the output register; one more word may be taken
// and stepped, then holds its result and blocks the input until the output frees.
module nlfsr_full_period_checker
   import nlfsr_pkg::*;
#(
   parameter int ORDER = 5
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // feedback_table[31:0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // full_period, returned_to_zero,
                                         // steps_taken[5:0], emitted_bits[31:0]
);

   localparam int PERIOD = 1 << ORDER;
   localparam int LIM    = PERIOD + 3;
   localparam logic [STEPS_W-1:0] PERIOD_SAT =
      STEPS_W'((PERIOD > 63) ? 63 : PERIOD);
   localparam logic [STEPS_W-1:0] LIMIT_SAT =
      STEPS_W'((LIM > 63) ? 63 : LIM);

   nlfsr_cmd_type      cmd;
   nlfsr_status_type   status;
   logic               full_period;
   logic               returned_to_zero;
   logic [STEPS_W-1:0] steps_taken;
   logic [BITS_W-1:0]  emitted_bits;

   nlfsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   nlfsr_dpath #(
      .ORDER (ORDER)
   ) u_dpath (
      .clock                (clock),
      .req_table            (req_tdata),
      .cmd                  (cmd),
      .status               (status),
      .rsp_full_period      (full_period),
      .rsp_returned_to_zero (returned_to_zero),
      .rsp_steps_taken      (steps_taken),
      .rsp_emitted_bits     (emitted_bits)
   );

   assign rsp_tdata = {emitted_bits, steps_taken, returned_to_zero, full_period};

   a_full_implies_return: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && full_period |-> returned_to_zero)
      else $error("full period without return to zero");

   a_full_step_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && full_period |-> steps_taken == PERIOD_SAT)
      else $error("full period with wrong step count");

   a_no_return_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !returned_to_zero |-> steps_taken == LIMIT_SAT)
      else $error("no return but step limit not reached");

   a_steps_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> steps_taken != '0 && steps_taken <= LIMIT_SAT)
      else $error("step count out of range");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !req_tready)
      else $error("input ready while stepping");

endmodule

// ===== rtl/nlfsr_ctrl.sv =====
// Controller state machine: load a table, step until done, hand off the result word.
module nlfsr_ctrl
   import nlfsr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output nlfsr_cmd_type    cmd,
   input  nlfsr_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (status.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/nlfsr_dpath.sv =====
// Datapath: shift register, step counter, emitted bits and the result register.
module nlfsr_dpath
   import nlfsr_pkg::*;
#(
   parameter int ORDER = 5
)
(
   input  logic                 clock,
   input  logic [TABLE_W-1:0]   req_table,
   input  nlfsr_cmd_type        cmd,
   output nlfsr_status_type     status,
   output logic                 rsp_full_period,
   output logic                 rsp_returned_to_zero,
   output logic [STEPS_W-1:0]   rsp_steps_taken,
   output logic [BITS_W-1:0]    rsp_emitted_bits
);

   localparam int PERIOD = 1 << ORDER;
   localparam int KEEP   = (PERIOD < BITS_W) ? PERIOD : BITS_W;
   localparam logic [CNT_W-1:0] LIMIT     = CNT_W'(PERIOD + 3);
   localparam logic [CNT_W-1:0] PERIOD_C  = CNT_W'(PERIOD);
   localparam logic [CNT_W-1:0] KEEP_C    = CNT_W'(KEEP);
   localparam logic [CNT_W-1:0] SAT_C     = CNT_W'((1 << STEPS_W) - 1);

   logic [TABLE_W-1:0]   table_ff;
   logic [ORDER-1:0]     reg_ff, reg_in;
   logic [CNT_W-1:0]     steps_ff, steps_in;
   logic [BITS_W-1:0]    bits_ff, bits_in;
   logic                 zero_ff, zero_in;
   logic [MAX_ORDER-1:0] reg_wide;
   logic [ORDER:0]       shifted;
   logic                 fb;

   logic                 full_ff;
   logic                 ret_ff;
   logic [STEPS_W-1:0]   count_ff;
   logic [BITS_W-1:0]    emit_ff;

   always_comb begin
      reg_wide = MAX_ORDER'(reg_ff);
      fb       = reg_wide[MAX_ORDER-1] ? 1'b0 : table_ff[reg_wide[4:0]];
      shifted  = {reg_ff, fb};
      reg_in   = shifted[ORDER-1:0];
      steps_in = steps_ff + CNT_W'(1);
      zero_in  = (reg_in == '0);
      bits_in  = bits_ff;
      if (steps_ff < KEEP_C) begin
         bits_in[steps_ff[4:0]] = reg_ff[0];
      end
   end

   assign status.last = zero_in || (steps_in == LIMIT);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         table_ff <= req_table;
         reg_ff   <= '0;
         steps_ff <= '0;
         bits_ff  <= '0;
         zero_ff  <= 1'b0;
      end else if (cmd.step) begin
         reg_ff   <= reg_in;
         steps_ff <= steps_in;
         bits_ff  <= bits_in;
         zero_ff  <= zero_in;
      end
      if (cmd.publish) begin
         full_ff  <= zero_ff && (steps_ff == PERIOD_C);
         ret_ff   <= zero_ff;
         count_ff <= (steps_ff > SAT_C) ? SAT_C[STEPS_W-1:0] : steps_ff[STEPS_W-1:0];
         emit_ff  <= bits_ff;
      end
   end

   assign rsp_full_period      = full_ff;
   assign rsp_returned_to_zero = ret_ff;
   assign rsp_steps_taken      = count_ff;
   assign rsp_emitted_bits     = emit_ff;

endmodule

// ===== sim/nlfsr_full_period_checker_tb.sv =====
// Testbench for the feedback shift register full period checker: predicted results vs. stream.
module nlfsr_full_period_checker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nlfsr_pkg::*;

   localparam int ORDER        = 5;
   localparam int RANDOM_WORDS = 530;
   localparam int PAUSE_AT     = 200;
   localparam int HOLD_AT      = 380;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int LIMIT_CYCLES = 200000;

   typedef struct packed {
      logic [31:0] emitted_bits;
      logic [5:0]  steps_taken;
      logic        returned_to_zero;
      logic        full_period;
   } period_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [31:0]      req_tdata = '0;   // feedback_table[31:0]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // full_period, returned_to_zero,
                                       // steps_taken[5:0], emitted_bits[31:0]

   logic [31:0]       table_q[$];
   period_result_type expected_q[$];
   int                total_words = 0;
   int                words_sent = 0;
   int                results_seen = 0;
   int                errors = 0;
   int                hold_left = 0;
   bit                hold_done = 1'b0;
   int                cycles = 0;

   nlfsr_full_period_checker #(.ORDER(ORDER)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic period_result_type predict_period(input logic [31:0] feedback_table);
      period_result_type res;
      int period;
      int step_limit;
      int keep;
      int state;
      int steps;
      int fb;
      bit zero_again;
      period     = 1 << ORDER;
      step_limit = period + 3;
      keep       = (period < 32) ? period : 32;
      state      = 0;
      steps      = 0;
      zero_again = 1'b0;
      res        = '0;
      while (steps < step_limit && !zero_again) begin
         if (steps < keep) begin
            res.emitted_bits[steps] = state[0];
         end
         fb    = (state < 32) ? int'(feedback_table[state]) : 0;
         state = ((state << 1) | fb) & (period - 1);
         steps++;
         if (state == 0) begin
            zero_again = 1'b1;
         end
      end
      res.full_period      = zero_again && (steps == period);
      res.returned_to_zero = zero_again;
      res.steps_taken      = (steps > 63) ? 6'd63 : 6'(steps);
      return res;
   endfunction

   // top register bit xor a random function of the rest: a permutation of states
   function automatic logic [31:0] make_nonsingular();
      logic [31:0] feedback_table;
      logic [31:0] g;
      int period;
      period         = 1 << ORDER;
      g              = $urandom;
      feedback_table = $urandom;
      for (int k = 0; k < 32; k++) begin
         if (k < period) begin
            feedback_table[k] = 1'((k >> (ORDER - 1)) & 1) ^ g[k & (period / 2 - 1)];
         end
      end
      return feedback_table;
   endfunction

   function automatic logic [31:0] find_de_bruijn();
      logic [31:0] candidate;
      period_result_type res;
      candidate = make_nonsingular();
      for (int tries = 0; tries < 400; tries++) begin
         res = predict_period(candidate);
         if (res.full_period) begin
            return candidate;
         end
         candidate = make_nonsingular();
      end
      return candidate;
   endfunction

   function automatic int send_idle_pct(input int count);
      if (count < PAUSE_AT) begin
         return 37;
      end else if (count < 2 * PAUSE_AT) begin
         return 77;
      end
      return 0;
   endfunction

   function automatic int recv_idle_pct(input int count);
      if (count < PAUSE_AT) begin
         return 77;
      end else if (count < 2 * PAUSE_AT) begin
         return 37;
      end
      return 0;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
      end
   endtask

   initial begin
      int pick;
      table_q.push_back(32'h0000_0000);
      table_q.push_back(32'hFFFF_FFFF);
      table_q.push_back(32'h7FFF_FFFF);
      table_q.push_back(32'hFFFF_FFFE);
      table_q.push_back(32'h0000_0001);
      table_q.push_back(32'h8000_0000);
      table_q.push_back(32'hAAAA_AAAA);
      table_q.push_back(32'h5555_5555);
      table_q.push_back(32'hFFFF_0000);
      table_q.push_back(32'h0000_FFFF);
      table_q.push_back(32'h0000_0003);
      table_q.push_back(32'h0000_8001);
      table_q.push_back(32'h7FFF_0001);
      for (int k = 0; k < 4; k++) begin
         table_q.push_back(find_de_bruijn());
      end
      table_q.push_back(make_nonsingular());
      table_q.push_back(make_nonsingular());
      table_q.push_back(~find_de_bruijn());
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            table_q.push_back(find_de_bruijn());
         end else if (pick < 75) begin
            table_q.push_back(make_nonsingular());
         end else if (pick < 85) begin
            table_q.push_back(find_de_bruijn() ^ (32'h1 << $urandom_range(31)));
         end else begin
            table_q.push_back($urandom);
         end
      end
      total_words = table_q.size();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (words_sent < total_words || expected_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   always @(posedge clock) begin
      logic offer;
      offer = req_tvalid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_q.push_back(predict_period(req_tdata));
            void'(table_q.pop_front());
            words_sent++;
            offer = 1'b0;
         end
         // hold off at the boundary until the block has drained
         if (!offer && table_q.size() > 0
             && !(words_sent == PAUSE_AT && expected_q.size() > 0)
             && $urandom_range(99) >= send_idle_pct(words_sent)) begin
            offer = 1'b1;
            req_tdata <= table_q[0];
         end
         req_tvalid <= offer;
      end
   end

   always @(posedge clock) begin
      period_result_type got;
      period_result_type want;
      logic ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            results_seen++;
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: word with no prediction, expected none actual %h",
                        $realtime, rsp_tdata);
            end else begin
               want = expected_q.pop_front();
               check_field("full_period", 32'(want.full_period), 32'(got.full_period));
               check_field("returned_to_zero", 32'(want.returned_to_zero),
                           32'(got.returned_to_zero));
               check_field("steps_taken", 32'(want.steps_taken), 32'(got.steps_taken));
               check_field("emitted_bits", want.emitted_bits, got.emitted_bits);
            end
         end
         if (results_seen == HOLD_AT && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else begin
            ready = $urandom_range(99) >= recv_idle_pct(results_seen);
         end
         rsp_tready <= ready;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
